[hdl/u8vd_pkg.sv]
package u8vd_pkg;

  // Replacement character for malformed or truncated input
  localparam logic [20:0] QMARK = 21'h00003F;

  // Bytes that bound the overlong, surrogate and range checks
  localparam logic [7:0] LEAD_MIN2    = 8'hC2;
  localparam logic [7:0] LEAD_E0      = 8'hE0;
  localparam logic [7:0] LEAD_SURR    = 8'hED;
  localparam logic [7:0] LEAD_F0      = 8'hF0;
  localparam logic [7:0] LEAD_MAX     = 8'hF4;
  localparam logic [7:0] CONT_A0      = 8'hA0;
  localparam logic [7:0] CONT_90      = 8'h90;
  localparam logic [7:0] CONT_8F      = 8'h8F;

  // Continuation bytes a byte asks for
  localparam logic [2:0] FC_ASCII = 3'd0;
  localparam logic [2:0] FC_ONE   = 3'd1;
  localparam logic [2:0] FC_BAD   = 3'd4;

  localparam int MAX_RES = 3;

  // One queue entry: the results caused by one input item
  typedef struct packed {
    logic [1:0]                cnt;
    logic [MAX_RES-1:0][20:0]  cp;
  } res_rec_t;

  function automatic logic [2:0] follow_count(input logic [7:0] c);
    logic [2:0] f;
    case (c) inside
      8'b0???????: f = FC_ASCII;
      8'b110?????: f = 3'd1;
      8'b1110????: f = 3'd2;
      8'b11110???: f = 3'd3;
      default:     f = FC_BAD;
    endcase
    return f;
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return c[7:6] == 2'b10;
  endfunction

  // Lone byte decoded as a complete run: ASCII gives itself, all else '?'
  function automatic logic [20:0] single(input logic [7:0] c);
    return c[7] ? QMARK : {13'd0, c};
  endfunction

  // Check and assemble a sequence of lead b0 and n continuation bytes
  function automatic logic [20:0] check_seq(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [1:0] n);
    logic [20:0] cp;
    cp = QMARK;
    case (n)
      2'd1: begin
        if (is_cont(b1) && b0 >= LEAD_MIN2)
          cp = {10'd0, b0[4:0], b1[5:0]};
      end
      2'd2: begin
        if (is_cont(b1) && is_cont(b2) &&
            !(b0 == LEAD_E0 && b1 < CONT_A0) &&
            !(b0 == LEAD_SURR && b1 >= CONT_A0))
          cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      end
      default: begin
        if (is_cont(b1) && is_cont(b2) && is_cont(b3) &&
            !(b0 == LEAD_F0 && b1 < CONT_90) &&
            !(b0 > LEAD_MAX || (b0 == LEAD_MAX && b1 > CONT_8F)))
          cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      end
    endcase
    return cp;
  endfunction

endpackage

[hdl/u8vd_front.sv]
module u8vd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_final,
  input  logic              q_full,
  output logic              q_push,
  output u8vd_pkg::res_rec_t q_rec
);

  logic [7:0] lead, lead_next;
  logic [7:0] held0, held0_next;
  logic [7:0] held1, held1_next;
  logic [1:0] hcnt, hcnt_next;

  logic       accept;
  logic [2:0] need;
  logic [2:0] fc;
  logic [2:0] fx;
  logic       complete;
  logic [7:0] b1, b2;
  u8vd_pkg::res_rec_t rec;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // Classify the byte against the open sequence
  always_comb begin
    need      = u8vd_pkg::follow_count(lead);
    fc        = u8vd_pkg::follow_count(in_byte);
    fx        = u8vd_pkg::follow_count(held0);
    complete  = ({1'b0, hcnt} + 3'd1) >= need;
    b1        = (hcnt == 2'd0) ? in_byte : held0;
    b2        = (hcnt == 2'd1) ? in_byte : held1;
    rec       = '0;
    lead_next  = lead;
    held0_next = held0;
    held1_next = held1;
    hcnt_next  = hcnt;
    if (lead != 8'd0) begin
      if (complete) begin
        rec.cnt   = 2'd1;
        rec.cp[0] = u8vd_pkg::check_seq(lead, b1, b2, in_byte, need[1:0]);
        lead_next = 8'd0;
        hcnt_next = 2'd0;
      end else if (in_final) begin
        // truncated end: lead gives '?', held bytes decode as a fresh run
        rec.cp[0] = u8vd_pkg::QMARK;
        if (hcnt == 2'd0) begin
          rec.cnt   = 2'd2;
          rec.cp[1] = u8vd_pkg::single(in_byte);
        end else if (fx == u8vd_pkg::FC_ONE) begin
          rec.cnt   = 2'd2;
          rec.cp[1] = u8vd_pkg::check_seq(held0, in_byte, 8'd0, 8'd0, 2'd1);
        end else begin
          rec.cnt   = 2'd3;
          rec.cp[1] = u8vd_pkg::single(held0);
          rec.cp[2] = u8vd_pkg::single(in_byte);
        end
        lead_next = 8'd0;
        hcnt_next = 2'd0;
      end else begin
        // sequence still short: keep the byte
        if (hcnt == 2'd0) held0_next = in_byte;
        else              held1_next = in_byte;
        hcnt_next = hcnt + 2'd1;
      end
    end else begin
      if (in_final || fc == u8vd_pkg::FC_ASCII || fc == u8vd_pkg::FC_BAD) begin
        rec.cnt   = 2'd1;
        rec.cp[0] = u8vd_pkg::single(in_byte);
      end else begin
        lead_next = in_byte;
        hcnt_next = 2'd0;
      end
    end
  end

  assign q_push = accept && (rec.cnt != 2'd0);
  assign q_rec  = rec;

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      lead <= 8'd0;
      hcnt <= 2'd0;
    end else if (accept) begin
      lead <= lead_next;
      hcnt <= hcnt_next;
    end
  end

  // Held continuation bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
  end

endmodule

[hdl/u8vd_fifo.sv]
module u8vd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u8vd_pkg::res_rec_t push_data,
  output logic               full,
  input  logic               pop,
  output u8vd_pkg::res_rec_t pop_data,
  output logic               empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8vd_pkg::res_rec_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_data;
  end

endmodule

[hdl/u8vd_back.sv]
module u8vd_back (
  input  logic               clk,
  input  logic               rst,
  input  u8vd_pkg::res_rec_t q_rec,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [20:0]        out_cp,
  output logic               out_last
);

  logic [1:0]  idx;
  logic        load;
  logic        last;
  logic [20:0] cp_sel;

  assign load = !q_empty && (!out_valid || out_ready);
  assign last = idx == (q_rec.cnt - 2'd1);

  // Pick the next result of the head entry
  always_comb begin
    case (idx)
      2'd0:    cp_sel = q_rec.cp[0];
      2'd1:    cp_sel = q_rec.cp[1];
      default: cp_sel = q_rec.cp[2];
    endcase
  end

  assign q_pop = load && last;

  // Result index within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cp   <= cp_sel;
      out_last <= last;
    end
  end

endmodule

[hdl/utf8_validating_decoder.sv]
// UTF-8 decoder with validation.
// Input stream: s_tdata[7:0] is one raw byte of the string, s_tlast marks its
// last byte. Output stream: m_tdata[20:0] is a code point (0x3F for malformed
// or truncated input), m_tlast is high on the last result of an input item.
// A byte that leaves a sequence open gives no result; a truncated final
// sequence gives up to three results.
// With the queue empty, the first result of an item reaches m_tvalid through
// the queue write and then the output register.
// Throughput: one byte per cycle while each byte gives at most one result
// and m_tready stays high. The output register sends one result per cycle
// while m_tready is high, so a byte with several results holds the back end
// until all are sent; the QUEUE_DEPTH entry queue lets input keep flowing
// meanwhile.
// When m_tready is low the output register holds its item; the queue fills
// and s_tready drops once QUEUE_DEPTH entries wait.
// Reset (rst, synchronous) closes any open sequence and empties the queue
// and the output register.
module utf8_validating_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tlast    // run_end
);

  u8vd_pkg::res_rec_t push_rec, head_rec;
  logic               push, pop, full, empty;
  logic [20:0]        cp;

  u8vd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_final (s_tlast),
    .q_full   (full),
    .q_push   (push),
    .q_rec    (push_rec)
  );

  u8vd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_rec),
    .full      (full),
    .pop       (pop),
    .pop_data  (head_rec),
    .empty     (empty)
  );

  u8vd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rec     (head_rec),
    .q_empty   (empty),
    .q_pop     (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_cp    (cp),
    .out_last  (m_tlast)
  );

  assign m_tdata = {3'd0, cp};

endmodule

[sim/utf8_validating_decoder_tb.sv]
module utf8_validating_decoder_tb;

  // Replacement character and most results per input item
  localparam logic [20:0] QMARK   = 21'h00003F;
  localparam int          MAX_RES = 3;

  // Code point bounds for overlong, surrogate and range checks
  localparam logic [20:0] MIN_2B  = 21'h000080;
  localparam logic [20:0] MIN_3B  = 21'h000800;
  localparam logic [20:0] MIN_4B  = 21'h010000;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;

  // Sequence length codes: trailing bytes a byte asks for
  localparam int LEN_ASCII = 0;
  localparam int LEN_BAD   = 4;

  localparam int RAND_ITEMS = 246;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIR_N = 24;

  // One input item, with an optional hand-written single result
  typedef struct packed {
    logic [7:0]  text;
    logic        fin;
    logic        typed;
    logic [20:0] cp;
  } text_item_t;

  typedef struct packed {
    logic [20:0] cp;
    logic        last;
  } cp_item_t;

  localparam text_item_t DIR_ROWS [DIR_N] = '{
    '{8'h00, 1'b0, 1'b1, 21'h000000},  // lowest ASCII
    '{8'h7F, 1'b1, 1'b1, 21'h00007F},  // highest ASCII, end of string
    '{8'hFF, 1'b0, 1'b1, QMARK},       // byte that cannot start anything
    '{8'h80, 1'b0, 1'b1, QMARK},       // stray continuation
    '{8'hC2, 1'b0, 1'b0, 21'h0},
    '{8'hA9, 1'b0, 1'b1, 21'h0000A9},
    '{8'hC0, 1'b0, 1'b0, 21'h0},       // overlong two-byte lead
    '{8'h80, 1'b0, 1'b1, QMARK},
    '{8'hE0, 1'b0, 1'b0, 21'h0},       // lowest three-byte value
    '{8'hA0, 1'b0, 1'b0, 21'h0},
    '{8'h80, 1'b0, 1'b1, 21'h000800},
    '{8'hED, 1'b0, 1'b0, 21'h0},       // surrogate
    '{8'hA0, 1'b0, 1'b0, 21'h0},
    '{8'h80, 1'b0, 1'b1, QMARK},
    '{8'hF4, 1'b0, 1'b0, 21'h0},       // above the code space
    '{8'h90, 1'b0, 1'b0, 21'h0},
    '{8'h80, 1'b0, 1'b0, 21'h0},
    '{8'h80, 1'b0, 1'b1, QMARK},
    '{8'hE2, 1'b0, 1'b0, 21'h0},       // truncated at end: two results
    '{8'h82, 1'b1, 1'b0, 21'h0},
    '{8'hF0, 1'b0, 1'b0, 21'h0},       // three leads cut short: three results
    '{8'hF0, 1'b0, 1'b0, 21'h0},
    '{8'hF0, 1'b1, 1'b0, 21'h0},
    '{8'hC3, 1'b1, 1'b1, QMARK}        // lead as last byte
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;

  utf8_validating_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  text_item_t  text_q[$];
  cp_item_t    cp_q[$];
  int          errors = 0;
  int          acc_n = 0;
  int          phase = 0;

  // Decoder state mirror
  logic [7:0]  open_lead;
  logic [7:0]  trail_buf [2];
  int          trail_cnt;
  logic [20:0] step_cp [MAX_RES];
  int          step_n;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int utf8_len(input logic [7:0] c);
    casez (c)
      8'b0???????: return LEN_ASCII;
      8'b110?????: return 1;
      8'b1110????: return 2;
      8'b11110???: return 3;
      default:     return LEN_BAD;
    endcase
  endfunction

  function automatic logic is_trail(input logic [7:0] c);
    return c[7:6] == 2'b10;
  endfunction

  // Value of a lead plus f trailing bytes; range checks catch overlongs,
  // surrogates and values past the code space
  function automatic logic [20:0] seq_value(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [7:0] c2, input logic [7:0] c3,
                                            input int f);
    logic [20:0] v;
    logic        ok;
    case (f)
      1: begin
        v  = {10'd0, c0[4:0], c1[5:0]};
        ok = is_trail(c1) && v >= MIN_2B;
      end
      2: begin
        v  = {5'd0, c0[3:0], c1[5:0], c2[5:0]};
        ok = is_trail(c1) && is_trail(c2) && v >= MIN_3B && !(v >= SURR_LO && v <= SURR_HI);
      end
      default: begin
        v  = {c0[2:0], c1[5:0], c2[5:0], c3[5:0]};
        ok = is_trail(c1) && is_trail(c2) && is_trail(c3) && v >= MIN_4B && v <= CP_MAX;
      end
    endcase
    return ok ? v : QMARK;
  endfunction

  task automatic add_cp(input logic [20:0] v);
    if (step_n < MAX_RES) begin
      step_cp[step_n] = v;
      step_n++;
    end
  endtask

  // Decode run[0..n-1] as a complete string
  task automatic decode_run(input logic [3:0][7:0] run, input int n);
    int i;
    int f;
    i = 0;
    while (i < n) begin
      f = utf8_len(run[i]);
      if (f == LEN_ASCII) begin
        add_cp({13'd0, run[i]});
        i++;
      end else if (f == LEN_BAD || i + f >= n) begin
        add_cp(QMARK);
        i++;
      end else begin
        add_cp(seq_value(run[i], run[(i + 1) & 3], run[(i + 2) & 3], run[(i + 3) & 3], f));
        i += f + 1;
      end
    end
  endtask

  // Advance the mirror by one accepted byte; results land in step_cp
  task automatic predict_byte(input logic [7:0] b, input logic fin);
    logic [3:0][7:0] run;
    int n;
    int f;
    step_n = 0;
    run = '0;
    if (open_lead != 8'h00) begin
      run[0] = open_lead;
      n = 1;
      if (trail_cnt > 0) begin
        run[n] = trail_buf[0];
        n++;
      end
      if (trail_cnt > 1) begin
        run[n] = trail_buf[1];
        n++;
      end
      run[n] = b;
      n++;
      if (fin || trail_cnt + 1 >= utf8_len(open_lead)) begin
        decode_run(run, n);
        open_lead = 8'h00;
        trail_cnt = 0;
      end else begin
        trail_buf[trail_cnt] = b;
        trail_cnt++;
      end
    end else begin
      f = utf8_len(b);
      if (fin || f == LEN_ASCII || f == LEN_BAD) begin
        run[0] = b;
        decode_run(run, 1);
      end else begin
        open_lead = b;
        trail_cnt = 0;
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin);
    text_q.push_back('{b, fin, 1'b0, 21'h0});
  endtask

  function automatic logic [7:0] rand_trail();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Random text: mostly well-formed sequences, with malformed ones and noise mixed in
  task automatic build_random_text();
    int          roll;
    int          cnt;
    logic [7:0]  lead;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        fin;
    logic [7:0]  nasty [9];
    nasty = '{8'hC0, 8'hC1, 8'hE0, 8'hED, 8'hF0, 8'hF4, 8'hF5, 8'hF6, 8'hF7};
    while (text_q.size() < DIR_N + RAND_ITEMS) begin
      roll = $urandom_range(0, 99);
      fin  = ($urandom_range(0, 5) == 0);
      if (roll < 18) begin
        // ASCII run
        cnt = $urandom_range(1, 4);
        for (int i = 0; i < cnt; i++) push_byte(8'($urandom_range(0, 127)), fin && i == cnt - 1);
      end else if (roll < 32) begin
        // valid two-byte
        push_byte(8'hC2 + 8'($urandom_range(0, 29)), 1'b0);
        push_byte(rand_trail(), fin);
      end else if (roll < 46) begin
        // valid three-byte
        lead = 8'hE0 + 8'($urandom_range(0, 15));
        lo = (lead == 8'hE0) ? 8'hA0 : 8'h80;
        hi = (lead == 8'hED) ? 8'h9F : 8'hBF;
        push_byte(lead, 1'b0);
        push_byte(8'($urandom_range(lo, hi)), 1'b0);
        push_byte(rand_trail(), fin);
      end else if (roll < 60) begin
        // valid four-byte
        lead = 8'hF0 + 8'($urandom_range(0, 4));
        lo = (lead == 8'hF0) ? 8'h90 : 8'h80;
        hi = (lead == 8'hF4) ? 8'h8F : 8'hBF;
        push_byte(lead, 1'b0);
        push_byte(8'($urandom_range(lo, hi)), 1'b0);
        push_byte(rand_trail(), 1'b0);
        push_byte(rand_trail(), fin);
      end else if (roll < 70) begin
        // boundary leads: overlong, surrogate, out of range
        lead = nasty[$urandom_range(0, 8)];
        cnt = utf8_len(lead);
        push_byte(lead, 1'b0);
        for (int i = 0; i < cnt; i++) push_byte(rand_trail(), fin && i == cnt - 1);
      end else if (roll < 78) begin
        // lead followed by arbitrary bytes
        lead = 8'hC0 + 8'($urandom_range(0, 55));
        cnt = utf8_len(lead);
        push_byte(lead, 1'b0);
        for (int i = 0; i < cnt; i++) push_byte(8'($urandom), fin && i == cnt - 1);
      end else if (roll < 88) begin
        // string ends inside a sequence
        lead = 8'hC0 + 8'($urandom_range(0, 55));
        cnt = $urandom_range(0, utf8_len(lead) - 1);
        push_byte(lead, cnt == 0);
        for (int i = 0; i < cnt; i++) begin
          push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : rand_trail(), i == cnt - 1);
        end
      end else begin
        // noise
        push_byte(8'($urandom), fin);
      end
    end
  endtask

  // Input side: predict at each accepted item
  always @(posedge clk) begin
    text_item_t it;
    if (!rst && s_tvalid && s_tready) begin
      it = text_q[acc_n];
      acc_n <= acc_n + 1;
      predict_byte(s_tdata, s_tlast);
      if (it.typed) begin
        cp_q.push_back('{it.cp, 1'b1});
      end else begin
        for (int i = 0; i < step_n; i++) cp_q.push_back('{step_cp[i], i == step_n - 1});
      end
    end
  end

  // Output side: compare with the oldest expectation
  always @(posedge clk) begin
    cp_item_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (cp_q.size() == 0) begin
        note_error($sformatf("unexpected result cp=%h last=%b", m_tdata, m_tlast));
      end else begin
        e = cp_q.pop_front();
        if (m_tdata !== {3'b000, e.cp} || m_tlast !== e.last) begin
          note_error($sformatf("cp exp %h got %h, last exp %b got %b",
                               e.cp, m_tdata, e.last, m_tlast));
        end
      end
    end
  end

  // Receiver: random stalls per phase, one long hold-off at the start of the last phase
  initial begin
    bit hold_done;
    int rx_idle;
    hold_done = 1'b0;
    m_tready = 1'b0;
    forever @(negedge clk) begin
      rx_idle = (phase == 0) ? 69 : (phase == 1) ? 27 : 0;
      if (phase == 2 && !hold_done) begin
        m_tready <= 1'b0;
        for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  // Reset, stimulus and end of run
  initial begin
    int total;
    int tx_idle;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    open_lead = 8'h00;
    trail_cnt = 0;
    step_n = 0;
    for (int i = 0; i < DIR_N; i++) text_q.push_back(DIR_ROWS[i]);
    build_random_text();
    total = text_q.size();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < total; i++) begin
      phase = (i < total / 3) ? 0 : (i < 2 * total / 3) ? 1 : 2;
      tx_idle = (phase == 0) ? 27 : (phase == 1) ? 69 : 0;
      while ($urandom_range(0, 99) < tx_idle) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= text_q[i].text;
      s_tlast  <= text_q[i].fin;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      @(negedge clk);
    end
    s_tvalid <= 1'b0;
    while (cp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("utf8_validating_decoder_tb passed");
    end else begin
      $display("utf8_validating_decoder_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("utf8_validating_decoder_tb failed");
    $finish;
  end

endmodule
